// File: sv/swst_pkg.sv
// ----------------------------------------------------------------------------
// swst_pkg
// Shared constants for the sliding window statistics block.
// ----------------------------------------------------------------------------
package swst_pkg;

  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  // configuration register file
  localparam int ADDR_BITS = 3;
  localparam int WS_BITS   = 9;
  localparam int DC_BITS   = 16;

  localparam logic [WS_BITS-1:0] WS_RESET = 9'd256;
  localparam logic [DC_BITS-1:0] DC_RESET = 16'd0;

  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_DROP_COUNT  = 1'b1;

  // input word kinds
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

endpackage

// File: sv/swst_if.sv
// ----------------------------------------------------------------------------
// swst_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface swst_in_if #(
  parameter int SAMPLE_BITS = swst_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, kind, sample, input ready);
  modport sink   (input valid, kind, sample, output ready);
endinterface

interface swst_out_if #(
  parameter int SAMPLE_BITS = swst_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_WINDOW  = swst_pkg::MAX_WINDOW_DEF
);
  localparam int CB = $clog2(MAX_WINDOW + 1);

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] mean;
  logic        [SAMPLE_BITS-1:0] std_dev;
  logic signed [SAMPLE_BITS-1:0] minimum;
  logic signed [SAMPLE_BITS-1:0] maximum;
  logic        [CB-1:0]          sample_count;
  logic signed [SAMPLE_BITS-1:0] last_value;
  logic                          populated;

  modport source (output valid, mean, std_dev, minimum, maximum, sample_count,
                  last_value, populated, input ready);
  modport sink   (input valid, mean, std_dev, minimum, maximum, sample_count,
                  last_value, populated, output ready);
endinterface

// File: sv/swst_mul.sv
// ----------------------------------------------------------------------------
// swst_mul
// Serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module swst_mul #(
  parameter int AW = 66,
  parameter int BW = 33
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic          done,
  output logic [AW-1:0] p
);

  localparam int NB = $clog2(BW + 1);

  logic          run;
  logic [NB-1:0] cnt;
  logic [AW-1:0] ma;
  logic [BW-1:0] mb;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= NB'(BW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == NB'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p  <= '0;
      ma <= a;
      mb <= b;
    end else if (run) begin
      if (mb[0]) begin
        p <= p + ma;
      end
      ma <= ma << 1;
      mb <= mb >> 1;
    end
  end

endmodule

// File: sv/swst_div.sv
// ----------------------------------------------------------------------------
// swst_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swst_div #(
  parameter int W = 66
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int NB = $clog2(W + 1);

  logic          run;
  logic [NB-1:0] cnt;
  logic [W-1:0]  rem;
  logic [W-1:0]  dv;
  logic [W:0]    trial;
  logic          ge;

  assign trial = {rem, quo[W-1]};
  assign ge    = trial >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= NB'(W);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == NB'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quo shifts the dividend out at the top and the quotient in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dv  <= den;
      quo <= num;
    end else if (run) begin
      rem <= ge ? W'(trial - {1'b0, dv}) : W'(trial);
      quo <= {quo[W-2:0], ge};
    end
  end

endmodule

// File: sv/swst_sqrt.sv
// ----------------------------------------------------------------------------
// swst_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module swst_sqrt #(
  parameter int W = 66
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     x,
  output logic             done,
  output logic [W/2-1:0]   root
);

  localparam int NB = $clog2(W / 2 + 1);

  logic          run;
  logic [NB-1:0] cnt;
  logic [W-1:0]  rx;
  logic [W-1:0]  rr;
  logic [W-1:0]  rb;
  logic [W-1:0]  trial;

  assign trial = rr + rb;
  assign root  = rr[W/2-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= NB'(W / 2);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == NB'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rx <= x;
      rr <= '0;
      rb <= W'(1) << (W - 2);
    end else if (run) begin
      if (rx >= trial) begin
        rx <= rx - trial;
        rr <= (rr >> 1) + rb;
      end else begin
        rr <= rr >> 1;
      end
      rb <= rb >> 2;
    end
  end

endmodule

// File: sv/sliding_window_statistics.sv
// ----------------------------------------------------------------------------
// sliding_window_statistics
// Mean, deviation, min, max over the most recent samples of a stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one word per push or clear (kind, sample); out_ch returns
//   exactly one result word for every input word, in order.
//   window_size and drop_count are written over the APB port while idle.
//   Steps per word: a stored sample costs an insert and a squaring in the
//   serial multiplier; an eviction adds a memory read and another squaring.
//   Then, unless the window is empty, a min/max rescan through the single
//   memory read port and the serial units: mean divide, then three
//   multiplies, variance divide and root when more than one sample is held.
//   One word is in flight at a time; in_ch.ready is high while idle.
//   A finished result sits in the output register; if out_ch stalls, the
//   next word may still be taken and is held at its end until the result
//   register frees.
//   Reset empties the window, clears the warm-up counter and sums, and sets
//   window_size to 256 and drop_count to 0. Window memory needs no clearing.
// ----------------------------------------------------------------------------
module sliding_window_statistics #(
  parameter int MAX_WINDOW  = swst_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = swst_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  swst_in_if.sink                        in_ch,
  swst_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swst_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int SB = SAMPLE_BITS;
  localparam int AB = $clog2(MAX_WINDOW);
  localparam int CB = $clog2(MAX_WINDOW + 1);
  localparam int SW = SB + CB;        // running sum
  localparam int NW = 2 * SW;         // squared terms and products

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_EV_RD    = 4'd1;
  localparam logic [3:0] ST_EV_MUL   = 4'd2;
  localparam logic [3:0] ST_INSERT   = 4'd3;
  localparam logic [3:0] ST_INS_MUL  = 4'd4;
  localparam logic [3:0] ST_STATS    = 4'd5;
  localparam logic [3:0] ST_SCAN     = 4'd6;
  localparam logic [3:0] ST_MEAN_DIV = 4'd7;
  localparam logic [3:0] ST_VAR_NUM  = 4'd8;
  localparam logic [3:0] ST_VAR_SQ   = 4'd9;
  localparam logic [3:0] ST_VAR_DEN  = 4'd10;
  localparam logic [3:0] ST_VAR_DIV  = 4'd11;
  localparam logic [3:0] ST_VAR_ROOT = 4'd12;
  localparam logic [3:0] ST_FINISH   = 4'd13;

  // ---- configuration registers ----
  logic [swst_pkg::WS_BITS-1:0] window_size;
  logic [swst_pkg::DC_BITS-1:0] drop_count;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= swst_pkg::WS_RESET;
      drop_count  <= swst_pkg::DC_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        swst_pkg::REG_WINDOW_SIZE: window_size <= pwdata[swst_pkg::WS_BITS-1:0];
        swst_pkg::REG_DROP_COUNT:  drop_count  <= pwdata[swst_pkg::DC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      swst_pkg::REG_WINDOW_SIZE: prdata = 32'(window_size);
      swst_pkg::REG_DROP_COUNT:  prdata = 32'(drop_count);
      default:                   prdata = '0;
    endcase
  end

  // ---- window state ----
  logic [3:0]                   state;
  logic [AB-1:0]                wp;
  logic [CB-1:0]                held;
  logic [swst_pkg::DC_BITS-1:0] dropped;
  logic signed [SW-1:0]         sum;
  logic [NW-1:0]                sqsum;
  logic signed [SB-1:0]         smp;
  logic signed [SB-1:0]         old;
  logic                         launched;

  // effective capacity: window_size clamped to 1..MAX_WINDOW
  logic [15:0]   ws16;
  logic [CB-1:0] cap;
  always_comb begin
    ws16 = 16'(window_size);
    if (ws16 == 16'd0) begin
      cap = CB'(1);
    end else if (ws16 > 16'(MAX_WINDOW)) begin
      cap = CB'(MAX_WINDOW);
    end else begin
      cap = CB'(ws16);
    end
  end

  // slot k places behind the write pointer, k in 0..MAX_WINDOW
  function automatic logic [AB-1:0] ring_back(input logic [AB-1:0] p,
                                              input logic [CB-1:0] k);
    logic [CB:0] t;
    t = (CB+1)'(p) + (CB+1)'(MAX_WINDOW) - (CB+1)'(k);
    if (t >= (CB+1)'(MAX_WINDOW)) begin
      t = t - (CB+1)'(MAX_WINDOW);
    end
    return t[AB-1:0];
  endfunction

  function automatic logic [SB-1:0] mag(input logic signed [SB-1:0] v);
    return v[SB-1] ? SB'(-v) : v;
  endfunction

  // ---- window memory ----
  logic signed [SB-1:0] mem [MAX_WINDOW];
  logic signed [SB-1:0] rdata;
  logic [AB-1:0]        rd_addr;
  logic [CB-1:0]        scan_idx;
  logic                 mem_we;

  assign mem_we  = (state == ST_INSERT);
  assign rd_addr = (state == ST_SCAN) ? ring_back(wp, scan_idx) : ring_back(wp, held);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= smp;
    end
    rdata <= mem[rd_addr];
  end

  // ---- shared serial units ----
  logic          mul_start, mul_done;
  logic [NW-1:0] mul_a, mul_p;
  logic [SW-1:0] mul_b;
  logic          div_start, div_done;
  logic [NW-1:0] div_num, div_den, div_q;
  logic          sqrt_start, sqrt_done;
  logic [SW-1:0] root;

  logic [SW-1:0] sum_mag;
  logic [NW-1:0] t_num, t_diff, t_den;

  assign sum_mag = sum[SW-1] ? SW'(-sum) : SW'(sum);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_EV_MUL: begin
        mul_a = NW'(mag(old));
        mul_b = SW'(mag(old));
      end
      ST_INS_MUL: begin
        mul_a = NW'(mag(smp));
        mul_b = SW'(mag(smp));
      end
      ST_VAR_NUM: begin
        mul_a = sqsum;
        mul_b = SW'(held);
      end
      ST_VAR_SQ: begin
        mul_a = NW'(sum_mag);
        mul_b = sum_mag;
      end
      ST_VAR_DEN: begin
        mul_a = NW'(held);
        mul_b = SW'(held - 1'b1);
      end
      default: ;
    endcase
  end

  assign mul_start  = !launched && (state == ST_EV_MUL || state == ST_INS_MUL ||
                      state == ST_VAR_NUM || state == ST_VAR_SQ || state == ST_VAR_DEN);
  assign div_start  = !launched && (state == ST_MEAN_DIV || state == ST_VAR_DIV);
  assign sqrt_start = !launched && (state == ST_VAR_ROOT);
  assign div_num    = (state == ST_MEAN_DIV) ? NW'(sum_mag) : t_diff;
  assign div_den    = (state == ST_MEAN_DIV) ? NW'(held) : t_den;

  swst_mul #(.AW(NW), .BW(SW)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .p(mul_p)
  );

  swst_div #(.W(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  swst_sqrt #(.W(NW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .x(div_q),
    .done(sqrt_done), .root(root)
  );

  // ---- result registers ----
  logic signed [SB-1:0] r_mean, r_min, r_max, r_last;
  logic        [SB-1:0] r_sd;
  logic                 scan_vld, scan_first;
  logic [SB-1:0]        mean_mag;

  assign mean_mag = div_q[SB-1:0];
  assign in_ch.ready = (state == ST_IDLE);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      wp           <= '0;
      held         <= '0;
      dropped      <= '0;
      sum          <= '0;
      sqsum        <= '0;
      launched     <= 1'b0;
      scan_vld     <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      // ST_FINISH owns valid in its own cycle
      if (out_ch.valid && out_ch.ready && state != ST_FINISH) begin
        out_ch.valid <= 1'b0;
      end
      if (mul_start || div_start || sqrt_start) begin
        launched <= 1'b1;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            smp <= in_ch.sample;
            if (in_ch.kind == swst_pkg::KIND_CLEAR) begin
              held    <= '0;
              wp      <= '0;
              dropped <= '0;
              sum     <= '0;
              sqsum   <= '0;
              state   <= ST_STATS;
            end else if (dropped < drop_count) begin
              dropped <= dropped + 1'b1;
              state   <= ST_STATS;
            end else if (held >= cap) begin
              state <= ST_EV_RD;
            end else begin
              state <= ST_INSERT;
            end
          end
        end

        ST_EV_RD: begin
          old   <= rdata;
          sum   <= sum - SW'(rdata);
          state <= ST_EV_MUL;
        end

        ST_EV_MUL: begin
          if (mul_done) begin
            launched <= 1'b0;
            sqsum    <= sqsum - mul_p;
            held     <= held - 1'b1;
            state    <= ST_INSERT;
          end
        end

        ST_INSERT: begin
          wp    <= (wp == AB'(MAX_WINDOW - 1)) ? '0 : wp + 1'b1;
          held  <= held + 1'b1;
          sum   <= sum + SW'(smp);
          state <= ST_INS_MUL;
        end

        ST_INS_MUL: begin
          if (mul_done) begin
            launched <= 1'b0;
            sqsum    <= sqsum + mul_p;
            state    <= ST_STATS;
          end
        end

        ST_STATS: begin
          r_mean   <= '0;
          r_sd     <= '0;
          r_min    <= '0;
          r_max    <= '0;
          r_last   <= '0;
          scan_idx <= CB'(1);
          scan_vld <= 1'b0;
          state    <= (held == '0) ? ST_FINISH : ST_SCAN;
        end

        // rescan newest to oldest; read data arrives in the cycle after its address
        ST_SCAN: begin
          scan_vld   <= (scan_idx <= held);
          scan_first <= (scan_idx == CB'(1));
          if (scan_idx <= held) begin
            scan_idx <= scan_idx + 1'b1;
          end
          if (scan_vld) begin
            if (scan_first) begin
              r_last <= rdata;
              r_min  <= rdata;
              r_max  <= rdata;
            end else begin
              if (rdata < r_min) r_min <= rdata;
              if (rdata > r_max) r_max <= rdata;
            end
          end else if (scan_idx > held) begin
            state <= ST_MEAN_DIV;
          end
        end

        ST_MEAN_DIV: begin
          if (div_done) begin
            launched <= 1'b0;
            r_mean   <= sum[SW-1] ? SB'(-mean_mag) : mean_mag;
            state    <= (held > CB'(1)) ? ST_VAR_NUM : ST_FINISH;
          end
        end

        ST_VAR_NUM: begin
          if (mul_done) begin
            launched <= 1'b0;
            t_num    <= mul_p;
            state    <= ST_VAR_SQ;
          end
        end

        ST_VAR_SQ: begin
          if (mul_done) begin
            launched <= 1'b0;
            t_diff   <= (t_num >= mul_p) ? t_num - mul_p : '0;
            state    <= ST_VAR_DEN;
          end
        end

        ST_VAR_DEN: begin
          if (mul_done) begin
            launched <= 1'b0;
            t_den    <= mul_p;
            state    <= ST_VAR_DIV;
          end
        end

        ST_VAR_DIV: begin
          if (div_done) begin
            launched <= 1'b0;
            state    <= ST_VAR_ROOT;
          end
        end

        ST_VAR_ROOT: begin
          if (sqrt_done) begin
            launched <= 1'b0;
            r_sd     <= (root > SW'({SB{1'b1}})) ? {SB{1'b1}} : root[SB-1:0];
            state    <= ST_FINISH;
          end
        end

        ST_FINISH: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid        <= 1'b1;
            out_ch.mean         <= r_mean;
            out_ch.std_dev      <= r_sd;
            out_ch.minimum      <= r_min;
            out_ch.maximum      <= r_max;
            out_ch.sample_count <= held;
            out_ch.last_value   <= r_last;
            out_ch.populated    <= (held != '0);
            state               <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
